[hw/rtl/mps_pkg.sv]
// mps_pkg: shared types and constants for the maze path depth-first search unit
// no dependencies; used by mps_ctrl, mps_dpath and maze_path_dfs_stack_unit

package mps_pkg;

  // grid geometry: the cell store is always 8 x 8, addressed {row, col}
  localparam int unsigned COORD_W   = 3;
  localparam int unsigned CELL_AW   = 2 * COORD_W;
  localparam int unsigned NUM_DIRS  = 4;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned OFS_W     = 2;
  localparam int unsigned NUM_CFG   = 2 * NUM_DIRS;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NBR_W     = COORD_W + 2;

  // cell codes held in the grid store
  localparam logic [1:0] CELL_OPEN    = 2'd0;
  localparam logic [1:0] CELL_WALL    = 2'd1;
  localparam logic [1:0] CELL_VISITED = 2'd2;

  // input function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // register reset values, row then column offset per direction
  localparam logic [OFS_W-1:0] DIR_RESET [NUM_CFG] = '{
    2'b00, 2'b01, 2'b01, 2'b00, 2'b00, 2'b11, 2'b11, 2'b00
  };

  // one stacked cell with the direction taken out of it
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DIR_W-1:0]   dir;
  } stk_entry_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CHECK,
    S_RESUME,
    S_EMIT,
    S_DRAIN_LD
  } mps_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // write one grid cell from the input transaction
    logic start;      // begin a search at the input cell
    logic probe_rd;   // read the grid at the current neighbor
    logic dir_inc;    // move on to the next direction
    logic step;       // push, enter and mark the neighbor
    logic pop_rd;     // read stack top and pop it
    logic pop_ld;     // resume from the popped entry
    logic out_goal;   // load result register with the goal
    logic out_none;   // load result register with not-found
    logic out_entry;  // load result register with the popped entry
  } mps_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic dir_done;   // all four directions tried
    logic nbr_off;    // neighbor lies outside the grid
    logic nbr_open;   // neighbor read back as open
    logic nbr_goal;   // neighbor is the goal cell
    logic stk_empty;  // stack holds no entry
    logic out_last;   // result register holds the final result
  } mps_sts_t;

endpackage

[hw/rtl/maze_path_dfs_stack_unit.sv]
// Maze path search unit. Grid cells load one per cycle (func 0) while the
// unit is idle. A search transaction (func 1) holds off intake while the
// depth-first walk runs: each tried neighbor takes one grid read through the
// single registered read port of the cell store, then the decision; a
// neighbor off the grid is skipped without a read, and each backtrack takes
// one stack read, then resume. Results then leave one at a time while
// out_tready is high, each stack entry taking one stack read before it is
// presented. Search time therefore grows with the number of cells visited.
// Visited marks stay in the grid, so the maze must be reloaded before the
// next search. The cell store needs no clearing after reset.
//
// maze_path_dfs_stack_unit: top level, joins controller and datapath
// depends on mps_pkg, mps_ctrl, mps_dpath

module maze_path_dfs_stack_unit #(
  parameter int unsigned ROWS        = 6,
  parameter int unsigned COLS        = 6,
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // cell_row, cell_col, cell_wall, pad
  input  logic                          in_tuser,   // func
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // path_row, path_col, is_start, pad
  output logic                          out_tuser,  // found
  output logic                          out_tlast,
  // configuration writes
  input  logic                          cfg_wr_en,
  input  logic [mps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mps_pkg::OFS_W-1:0]     cfg_data
);
  import mps_pkg::*;

  mps_cmd_t           cmd;
  mps_sts_t           sts;
  logic               res_found, res_is_start;
  logic [COORD_W-1:0] res_row, res_col;

  mps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_func    (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  mps_dpath #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_row       (in_tdata[2:0]),
    .in_col       (in_tdata[5:3]),
    .in_wall      (in_tdata[6]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sts          (sts),
    .out_found    (res_found),
    .out_row      (res_row),
    .out_col      (res_col),
    .out_is_start (res_is_start),
    .out_last     (out_tlast)
  );

  // result packing
  assign out_tdata = {1'b0, res_is_start, res_col, res_row};
  assign out_tuser = res_found;

`ifndef ASSERT_OFF
  // intake and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("intake open while a result is pending");

  // a search transaction closes intake on the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> !in_tready)
    else $error("intake still open after a search transaction");

  // the final result transaction reopens intake
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("intake not reopened after the final result");
`endif

endmodule

[hw/rtl/mps_ctrl.sv]
// mps_ctrl: search sequencer state machine for the maze path unit
// depends on mps_pkg; drives mps_dpath through mps_cmd_t, reads mps_sts_t

module mps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_func,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  input  mps_pkg::mps_sts_t sts,
  output mps_pkg::mps_cmd_t cmd
);
  import mps_pkg::*;

  mps_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && (in_func == FUNC_SEARCH)) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        priority if (sts.dir_done) begin
          state_nxt = sts.stk_empty ? S_EMIT : S_RESUME;
        end else if (!sts.nbr_off) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.nbr_open && sts.nbr_goal) state_nxt = S_EMIT;
        else state_nxt = S_PROBE;
      end
      S_RESUME: state_nxt = S_PROBE;
      S_EMIT: begin
        if (out_tready) state_nxt = sts.out_last ? S_IDLE : S_DRAIN_LD;
      end
      S_DRAIN_LD: state_nxt = S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid && (in_func == FUNC_LOAD);
        cmd.start = in_tvalid && (in_func == FUNC_SEARCH);
      end
      S_PROBE: begin
        priority if (sts.dir_done) begin
          cmd.out_none = sts.stk_empty;
          cmd.pop_rd   = !sts.stk_empty;
        end else if (sts.nbr_off) begin
          cmd.dir_inc = 1'b1;
        end else begin
          cmd.probe_rd = 1'b1;
        end
      end
      S_CHECK: begin
        cmd.dir_inc  = !sts.nbr_open;
        cmd.step     = sts.nbr_open;
        cmd.out_goal = sts.nbr_open && sts.nbr_goal;
      end
      S_RESUME: cmd.pop_ld = 1'b1;
      S_EMIT: begin
        out_tvalid = 1'b1;
        cmd.pop_rd = out_tready && !sts.out_last;
      end
      S_DRAIN_LD: cmd.out_entry = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

[hw/rtl/mps_dpath.sv]
// mps_dpath: grid store, path stack, walk registers and result register
// depends on mps_pkg; commanded by mps_ctrl

module mps_dpath #(
  parameter int unsigned ROWS        = 6,
  parameter int unsigned COLS        = 6,
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mps_pkg::mps_cmd_t             cmd,
  input  logic [mps_pkg::COORD_W-1:0]   in_row,
  input  logic [mps_pkg::COORD_W-1:0]   in_col,
  input  logic                          in_wall,
  input  logic                          cfg_wr_en,
  input  logic [mps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mps_pkg::OFS_W-1:0]     cfg_data,
  output mps_pkg::mps_sts_t             sts,
  output logic                          out_found,
  output logic [mps_pkg::COORD_W-1:0]   out_row,
  output logic [mps_pkg::COORD_W-1:0]   out_col,
  output logic                          out_is_start,
  output logic                          out_last
);
  import mps_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SP_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [NBR_W-1:0] GOAL_ROW = NBR_W'(ROWS);
  localparam logic [NBR_W-1:0] GOAL_COL = NBR_W'(COLS);

  logic [OFS_W-1:0]   dir_r [NUM_CFG];
  logic [1:0]         grid_mem [2**CELL_AW];
  stk_entry_t         stk_mem [STACK_DEPTH];
  logic [1:0]         grid_rdata_r;
  stk_entry_t         stk_rdata_r;
  logic [COORD_W-1:0] x_r, y_r, start_row_r, start_col_r;
  logic [DIR_W:0]     d_r;
  logic [CNT_W-1:0]   top_r;

  logic [OFS_W-1:0]   drow, dcol;
  logic [NBR_W-1:0]   nr, nc;
  logic [CELL_AW-1:0] nbr_addr;
  logic               push_ok;
  logic               gw_en;
  logic [CELL_AW-1:0] gw_addr;
  logic [1:0]         gw_data;
  logic [SP_W-1:0]    push_idx, pop_idx;
  stk_entry_t         push_entry;

  // direction registers, written from the configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_RESET;
    end else if (cfg_wr_en) begin
      dir_r[cfg_index] <= cfg_data;
    end
  end

  // neighbor of the current cell in the current direction
  always_comb begin
    drow     = dir_r[{d_r[DIR_W-1:0], 1'b0}];
    dcol     = dir_r[{d_r[DIR_W-1:0], 1'b1}];
    nr       = {2'b00, x_r} + {{(NBR_W-OFS_W){drow[OFS_W-1]}}, drow};
    nc       = {2'b00, y_r} + {{(NBR_W-OFS_W){dcol[OFS_W-1]}}, dcol};
    nbr_addr = {nr[COORD_W-1:0], nc[COORD_W-1:0]};
    push_ok  = top_r < CNT_FULL;
  end

  // grid write port: cell load, start mark or visit mark
  always_comb begin
    gw_en   = cmd.load || cmd.start || cmd.step;
    gw_addr = cmd.step ? nbr_addr : {in_row, in_col};
    gw_data = cmd.load ? {1'b0, in_wall} : CELL_VISITED;
  end

  // grid store
  always_ff @(posedge clk) begin
    if (gw_en) grid_mem[gw_addr] <= gw_data;
    if (cmd.probe_rd) grid_rdata_r <= grid_mem[nbr_addr];
  end

  // path stack
  always_comb begin
    push_idx   = top_r[SP_W-1:0];
    pop_idx    = SP_W'(top_r - CNT_ONE);
    push_entry = '{row: x_r, col: y_r, dir: d_r[DIR_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.step && push_ok) stk_mem[push_idx] <= push_entry;
    if (cmd.pop_rd) stk_rdata_r <= stk_mem[pop_idx];
  end

  // stack fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
    end else if (cmd.start) begin
      top_r <= '0;
    end else if (cmd.step && push_ok) begin
      top_r <= top_r + CNT_ONE;
    end else if (cmd.pop_rd) begin
      top_r <= top_r - CNT_ONE;
    end
  end

  // walk position, direction and start cell
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r         <= in_row;
      y_r         <= in_col;
      start_row_r <= in_row;
      start_col_r <= in_col;
      d_r         <= '0;
    end else if (cmd.step) begin
      x_r <= nr[COORD_W-1:0];
      y_r <= nc[COORD_W-1:0];
      d_r <= '0;
    end else if (cmd.pop_ld) begin
      x_r <= stk_rdata_r.row;
      y_r <= stk_rdata_r.col;
      d_r <= {1'b0, stk_rdata_r.dir} + (DIR_W+1)'(1);
    end else if (cmd.dir_inc) begin
      d_r <= d_r + (DIR_W+1)'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    priority if (cmd.out_none) begin
      out_found    <= 1'b0;
      out_row      <= '0;
      out_col      <= '0;
      out_is_start <= 1'b0;
      out_last     <= 1'b1;
    end else if (cmd.out_goal) begin
      out_found    <= 1'b1;
      out_row      <= nr[COORD_W-1:0];
      out_col      <= nc[COORD_W-1:0];
      out_is_start <= 1'b0;
      out_last     <= !push_ok && (top_r == '0);
    end else if (cmd.out_entry) begin
      out_found    <= 1'b1;
      out_row      <= stk_rdata_r.row;
      out_col      <= stk_rdata_r.col;
      out_is_start <= (stk_rdata_r.row == start_row_r) && (stk_rdata_r.col == start_col_r);
      out_last     <= top_r == '0;
    end else begin
      out_found <= out_found;
    end
  end

  // status to the controller
  always_comb begin
    sts.dir_done  = d_r[DIR_W];
    sts.nbr_off   = (nr[NBR_W-1:COORD_W] != '0) || (nc[NBR_W-1:COORD_W] != '0);
    sts.nbr_open  = grid_rdata_r == CELL_OPEN;
    sts.nbr_goal  = (nr == GOAL_ROW) && (nc == GOAL_COL);
    sts.stk_empty = top_r == '0;
    sts.out_last  = out_last;
  end

endmodule

[verif/testbench.sv]
// testbench: self-checking bench for maze_path_dfs_stack_unit, with a depth-first
// search predictor and a result queue held in a small scoreboard class
// depends on mps_pkg and the maze_path_dfs_stack_unit rtl

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mps_pkg::*;

  localparam int unsigned ROWS        = 6;
  localparam int unsigned COLS        = 6;
  localparam int unsigned STACK_DEPTH = 64;
  localparam int GRID_DIM      = 8;
  localparam int NUM_CELLS     = GRID_DIM * GRID_DIM;
  localparam int GOAL_ADDR     = ROWS * GRID_DIM + COLS;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 10;
  localparam longint CYCLE_LIMIT = 1000000;

  // grid code the bench uses for a cell it has not loaded yet
  localparam logic [1:0] CELL_UNSET = 2'd3;

  // direction offsets as 2-bit two's complement
  localparam logic [OFS_W-1:0] OFS_M2 = 2'b10;
  localparam logic [OFS_W-1:0] OFS_M1 = 2'b11;
  localparam logic [OFS_W-1:0] OFS_0  = 2'b00;
  localparam logic [OFS_W-1:0] OFS_P1 = 2'b01;

  typedef enum int {
    REG_DIR0_DROW, REG_DIR0_DCOL, REG_DIR1_DROW, REG_DIR1_DCOL,
    REG_DIR2_DROW, REG_DIR2_DCOL, REG_DIR3_DROW, REG_DIR3_DCOL
  } dir_reg_e;

  typedef logic [OFS_W-1:0] dir_setting_t [NUM_CFG];

  // one result transaction, packed in port order
  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               is_start;
    logic               last;
  } path_cell_t;

  // predictor of the search and queue of path cells still to arrive
  class maze_scoreboard;
    logic [OFS_W-1:0] offset [NUM_CFG];
    logic [1:0]       grid [NUM_CELLS];
    stk_entry_t       trail [STACK_DEPTH];
    int               depth;
    path_cell_t       expected_path [$];
    int               mismatches;
    int               checked;
    int               searches;
    int               found_paths;

    function new();
      offset = DIR_RESET;
      foreach (grid[i]) grid[i] = CELL_UNSET;
      depth       = 0;
      mismatches  = 0;
      checked     = 0;
      searches    = 0;
      found_paths = 0;
    endfunction

    function void note_setting(int idx, logic [OFS_W-1:0] value);
      offset[idx] = value;
    endfunction

    function int pending();
      return expected_path.size();
    endfunction

    // a load writes one cell, a search predicts its whole path
    function void record_item(logic func, logic [2:0] row, logic [2:0] col, logic wall);
      if (func == FUNC_LOAD) begin
        grid[row * GRID_DIM + col] = {1'b0, wall};
      end else begin
        search_path(row, col);
      end
    endfunction

    function int offset_of(int k);
      return offset[k][1] ? int'(offset[k]) - 4 : int'(offset[k]);
    endfunction

    function void expect_cell(logic found, int row, int col, logic is_start, logic last);
      path_cell_t exp_cell;
      exp_cell.found    = found;
      exp_cell.row      = row[2:0];
      exp_cell.col      = col[2:0];
      exp_cell.is_start = is_start;
      exp_cell.last     = last;
      expected_path.push_back(exp_cell);
    endfunction

    // depth-first walk with an explicit stack of (cell, direction taken)
    function void search_path(logic [2:0] r0, logic [2:0] c0);
      int x, y, d, ni, nj;
      stk_entry_t e;
      searches++;
      depth = 0;
      x = int'(r0);
      y = int'(c0);
      d = 0;
      grid[x * GRID_DIM + y] = CELL_VISITED;
      while (1) begin
        while (d < NUM_DIRS) begin
          ni = x + offset_of(2 * d);
          nj = y + offset_of(2 * d + 1);
          // off the grid counts as a wall
          if (ni < 0 || ni >= GRID_DIM || nj < 0 || nj >= GRID_DIM ||
              grid[ni * GRID_DIM + nj] != CELL_OPEN) begin
            d++;
            continue;
          end
          // push is dropped when the stack is full
          if (depth < STACK_DEPTH) begin
            e.row = x[2:0];
            e.col = y[2:0];
            e.dir = d[1:0];
            trail[depth] = e;
            depth++;
          end
          x = ni;
          y = nj;
          grid[x * GRID_DIM + y] = CELL_VISITED;
          if (x == ROWS && y == COLS) begin
            // goal first, then the stack from top to bottom
            found_paths++;
            expect_cell(1'b1, x, y, 1'b0, depth == 0);
            while (depth > 0) begin
              depth--;
              e = trail[depth];
              expect_cell(1'b1, int'(e.row), int'(e.col), e.row == r0 && e.col == c0,
                          depth == 0);
            end
            return;
          end
          d = 0;
        end
        // backtrack and resume with the next direction
        if (depth == 0) break;
        depth--;
        e = trail[depth];
        x = int'(e.row);
        y = int'(e.col);
        d = int'(e.dir) + 1;
      end
      expect_cell(1'b0, 0, 0, 1'b0, 1'b1);
    endfunction

    function void compare_field(string field, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    // compare one result transaction against the oldest expected cell
    function void check_path_cell(path_cell_t got);
      path_cell_t want;
      if (expected_path.size() == 0) begin
        $error("unexpected result: found %0b row %0d col %0d", got.found, got.row, got.col);
        mismatches++;
        return;
      end
      want = expected_path.pop_front();
      checked++;
      compare_field("found", 3'(want.found), 3'(got.found));
      compare_field("path_row", want.row, got.row);
      compare_field("path_col", want.col, got.col);
      compare_field("is_start", 3'(want.is_start), 3'(got.is_start));
      compare_field("last", 3'(want.last), 3'(got.last));
    endfunction
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;    // cell_row, cell_col, cell_wall, pad
  logic                 in_tuser   = 1'b0;  // func
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;          // path_row, path_col, is_start, pad
  logic                 out_tuser;          // found
  logic                 out_tlast;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [OFS_W-1:0]     cfg_data   = '0;

  maze_scoreboard board = new();
  logic   maze_plan [NUM_CELLS];
  int     in_idle_pct   = 0;
  int     out_stall_pct = 0;
  int     items_sent    = 0;
  int     settings_used = 0;
  longint cycle_count   = 0;

  maze_path_dfs_stack_unit #(
    .ROWS(ROWS),
    .COLS(COLS),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial forever #6 clk = ~clk;

  // result side: check accepted transactions, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_path_cell({out_tuser, out_tdata[2:0], out_tdata[5:3], out_tdata[6], out_tlast});
    end
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(logic func, logic [2:0] row, logic [2:0] col, logic wall);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {1'b0, wall, col, row};
    do @(posedge clk); while (!in_tready);
    board.record_item(func, row, col, wall);
    items_sent++;
  endtask

  // hold the sender until every expected cell is back and the block is quiet
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(dir_setting_t setting);
    drain_results();
    for (int k = REG_DIR0_DROW; k <= REG_DIR3_DCOL; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= k[CFG_IDX_W-1:0];
      cfg_data  <= setting[k];
      @(posedge clk);
      board.note_setting(k, setting[k]);
    end
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // bordered maze with random interior walls, goal kept open
  function automatic void plan_maze(int wall_pct);
    for (int r = 0; r < GRID_DIM; r++) begin
      for (int c = 0; c < GRID_DIM; c++) begin
        maze_plan[r * GRID_DIM + c] =
            (r == 0 || c == 0 || r == GRID_DIM - 1 || c == GRID_DIM - 1) ? 1'b1 :
            ($urandom_range(99) < wall_pct);
      end
    end
    maze_plan[GOAL_ADDR] = 1'b0;
  endfunction

  // reload every cell that differs from the plan (visited marks included)
  task automatic restore_maze();
    int base;
    int addr;
    base = $urandom_range(NUM_CELLS - 1);
    for (int i = 0; i < NUM_CELLS; i++) begin
      addr = (base + i) % NUM_CELLS;
      if (board.grid[addr] != {1'b0, maze_plan[addr]}) begin
        send_item(FUNC_LOAD, COORD_W'(addr / GRID_DIM), COORD_W'(addr % GRID_DIM),
                  maze_plan[addr]);
      end
    end
  endtask

  function automatic void pick_open_start(output logic [2:0] row, output logic [2:0] col);
    row = 3'd1;
    col = 3'd1;
    repeat (32) begin
      row = COORD_W'($urandom_range(GRID_DIM - 2, 1));
      col = COORD_W'($urandom_range(GRID_DIM - 2, 1));
      if (!maze_plan[row * GRID_DIM + col]) return;
    end
  endfunction

  // mostly clean searches on a restored maze, some on stale or damaged grids
  task automatic random_round();
    int kind;
    logic [2:0] row, col;
    kind = $urandom_range(99);
    row  = COORD_W'($urandom_range(GRID_DIM - 1));
    col  = COORD_W'($urandom_range(GRID_DIM - 1));
    if (kind < 70) begin
      if ($urandom_range(5) == 0) begin
        plan_maze($urandom_range(45, 10));
      end else begin
        repeat ($urandom_range(3)) begin
          maze_plan[$urandom_range(GRID_DIM - 2, 1) * GRID_DIM +
                    $urandom_range(GRID_DIM - 2, 1)] = 1'($urandom_range(1));
        end
      end
      maze_plan[GOAL_ADDR] = 1'b0;
      restore_maze();
      pick_open_start(row, col);
    end else if (kind < 80) begin
      // search again on the visited floor
    end else if (kind < 92) begin
      // stray loads anywhere, border included
      repeat ($urandom_range(4, 1)) begin
        send_item(FUNC_LOAD, COORD_W'($urandom_range(GRID_DIM - 1)),
                  COORD_W'($urandom_range(GRID_DIM - 1)), 1'($urandom_range(1)));
      end
    end else begin
      restore_maze();
    end
    send_item(FUNC_SEARCH, row, col, 1'($urandom_range(1)));
    if ($urandom_range(7) == 0) drain_results();
  endtask

  initial begin
    dir_setting_t setting;
    int phase_goal;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on an open bordered floor, reset directions
    plan_maze(0);
    restore_maze();
    send_item(FUNC_SEARCH, 3'd1, 3'd1, 1'b0);
    // start on the goal is never reported
    restore_maze();
    send_item(FUNC_SEARCH, COORD_W'(ROWS), COORD_W'(COLS), 1'b1);
    // start next to the goal
    restore_maze();
    send_item(FUNC_SEARCH, COORD_W'(ROWS), COORD_W'(COLS - 1), 1'b0);
    // goal left visited: no path
    send_item(FUNC_SEARCH, 3'd1, 3'd1, 1'b0);
    // wall starts on the border, some neighbors off the grid
    restore_maze();
    send_item(FUNC_SEARCH, 3'd0, 3'd0, 1'b0);
    send_item(FUNC_SEARCH, 3'd7, 3'd7, 1'b1);
    // walled-in goal
    maze_plan[GOAL_ADDR] = 1'b1;
    restore_maze();
    send_item(FUNC_SEARCH, 3'd1, 3'd1, 1'b0);
    maze_plan[GOAL_ADDR] = 1'b0;

    // extreme offsets: all zero, all -2, all +1, all -1
    foreach (setting[k]) setting[k] = OFS_0;
    write_setting(setting);
    restore_maze();
    send_item(FUNC_SEARCH, 3'd3, 3'd3, 1'b0);
    foreach (setting[k]) setting[k] = OFS_M2;
    write_setting(setting);
    restore_maze();
    send_item(FUNC_SEARCH, 3'd5, 3'd5, 1'b0);
    foreach (setting[k]) setting[k] = OFS_P1;
    write_setting(setting);
    restore_maze();
    send_item(FUNC_SEARCH, 3'd1, 3'd1, 1'b0);
    foreach (setting[k]) setting[k] = OFS_M1;
    write_setting(setting);
    restore_maze();
    send_item(FUNC_SEARCH, 3'd7, 3'd7, 1'b0);

    // random phases, each with its own directions and idling
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: setting = DIR_RESET;
        1: setting = '{OFS_M1, OFS_0, OFS_0, OFS_M1, OFS_P1, OFS_0, OFS_0, OFS_P1};
        2: setting = '{OFS_P1, OFS_P1, OFS_0, OFS_P1, OFS_P1, OFS_0, OFS_M2, OFS_M1};
        default: foreach (setting[k]) setting[k] = OFS_W'($urandom_range(3));
      endcase
      write_setting(setting);
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 78; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 78; end
        default: begin in_idle_pct = 15; out_stall_pct = 15; end
      endcase
      plan_maze($urandom_range(40, 15));
      phase_goal = items_sent + PHASE_ITEMS;
      while (items_sent < phase_goal) random_round();
    end

    drain_results();
    $display("covered %0d searches (%0d reached the goal) under %0d direction settings",
             board.searches, board.found_paths, settings_used);
    $display("%0d input transactions sent, %0d result transactions checked",
             items_sent, board.checked);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
